FILE: rtl/pairwise_vector_distance_macros.svh
// Assertion macros shared by the pairwise vector distance RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef PAIRWISE_VECTOR_DISTANCE_MACROS_SVH
`define PAIRWISE_VECTOR_DISTANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PVD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pvd assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define PVD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pvd assertion failed (next cycle)");

`endif

FILE: rtl/pvd_pkg.sv
// Package for the pairwise vector distance block: widths, metric codes and
// the job record passed from the accumulator to the finishing engine. No dependencies.
`default_nettype none
package pvd_pkg;
    localparam int ELEM_W        = 16;
    localparam int SUM_W         = 48;
    localparam int DIST_W        = 32;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int FRAC_BITS_DEF = 12;

    typedef enum logic [1:0] {
        METRIC_CITYBLOCK = 2'd0,
        METRIC_EUCLID    = 2'd1,
        METRIC_COSINE    = 2'd2,
        METRIC_NONE      = 2'd3
    } metric_t;

    typedef struct packed {
        metric_t            mode;
        logic [SUM_W-1:0]   primary;
        logic [SUM_W-1:0]   norm_a;
        logic [SUM_W-1:0]   norm_b;
    } pvd_job_t;
endpackage
`default_nettype wire

FILE: rtl/pvd_front.sv
// Front end: takes element pairs, squares/multiplies them in one stage and
// accumulates the three saturating sums; the last pair pushes a job. Uses pvd_pkg.
`default_nettype none
module pvd_front
    import pvd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,
    input  wire logic              s_tlast,
    output logic                   job_push,
    output pvd_job_t               job_data,
    input  wire logic              job_ready
);
    metric_t                   mode_reg;
    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    metric_t                   s1_mode_reg;
    logic signed [35:0]        s1_pterm_reg;
    logic [31:0]               s1_aa_reg;
    logic [31:0]               s1_bb_reg;
    logic [SUM_W-1:0]          psum_reg;
    logic [SUM_W-1:0]          nasum_reg;
    logic [SUM_W-1:0]          nbsum_reg;

    logic signed [ELEM_W-1:0]  a_elem;
    logic signed [ELEM_W-1:0]  b_elem;
    logic signed [ELEM_W:0]    d_val;
    logic [ELEM_W:0]           d_abs;
    logic signed [17:0]        mul_x;
    logic signed [17:0]        mul_y;
    logic signed [35:0]        mul_p;
    logic signed [35:0]        pterm;
    logic                      stall;
    logic                      accept;
    logic signed [SUM_W:0]     ps_signed;
    logic [SUM_W:0]            ps_unsigned;
    logic [SUM_W-1:0]          psum_next;
    logic [SUM_W:0]            na_wide;
    logic [SUM_W:0]            nb_wide;
    logic [SUM_W-1:0]          nasum_next;
    logic [SUM_W-1:0]          nbsum_next;

    assign a_elem = s_tdata[ELEM_W-1:0];
    assign b_elem = s_tdata[2*ELEM_W-1:ELEM_W];
    assign d_val  = (ELEM_W+1)'(a_elem) - (ELEM_W+1)'(b_elem);
    assign d_abs  = d_val[ELEM_W] ? (ELEM_W+1)'(-d_val) : d_val;

    always_comb begin
        if (mode_reg == METRIC_EUCLID) begin
            mul_x = $signed({1'b0, d_abs});
            mul_y = $signed({1'b0, d_abs});
        end else begin
            mul_x = 18'(a_elem);
            mul_y = 18'(b_elem);
        end
        mul_p = mul_x * mul_y;
        case (mode_reg)
            METRIC_CITYBLOCK: pterm = $signed({19'd0, d_abs});
            METRIC_EUCLID,
            METRIC_COSINE:    pterm = mul_p;
            default:          pterm = '0;
        endcase
    end

    // Only a closing pair needs queue space; everything else flows.
    assign stall    = s1_valid_reg && s1_last_reg && !job_ready;
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ps_signed   = $signed({psum_reg[SUM_W-1], psum_reg})
                    + (SUM_W+1)'(s1_pterm_reg);
        ps_unsigned = {1'b0, psum_reg} + (SUM_W+1)'($unsigned(s1_pterm_reg));
        if (s1_mode_reg == METRIC_COSINE) begin
            if (ps_signed[SUM_W] != ps_signed[SUM_W-1])
                psum_next = ps_signed[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
            else
                psum_next = ps_signed[SUM_W-1:0];
        end else begin
            psum_next = ps_unsigned[SUM_W] ? '1 : ps_unsigned[SUM_W-1:0];
        end
        na_wide    = {1'b0, nasum_reg} + (SUM_W+1)'(s1_aa_reg);
        nb_wide    = {1'b0, nbsum_reg} + (SUM_W+1)'(s1_bb_reg);
        nasum_next = na_wide[SUM_W] ? '1 : na_wide[SUM_W-1:0];
        nbsum_next = nb_wide[SUM_W] ? '1 : nb_wide[SUM_W-1:0];
    end

    assign job_push       = s1_valid_reg && s1_last_reg && job_ready;
    assign job_data.mode    = s1_mode_reg;
    assign job_data.primary = psum_next;
    assign job_data.norm_a  = nasum_next;
    assign job_data.norm_b  = nbsum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= METRIC_CITYBLOCK;
            s1_valid_reg <= 1'b0;
            psum_reg     <= '0;
            nasum_reg    <= '0;
            nbsum_reg    <= '0;
        end else begin
            if (cfg_wr_en)
                mode_reg <= metric_t'(cfg_wr_data);
            if (!stall) begin
                s1_valid_reg <= accept;
                if (s1_valid_reg) begin
                    if (s1_last_reg) begin
                        psum_reg  <= '0;
                        nasum_reg <= '0;
                        nbsum_reg <= '0;
                    end else begin
                        psum_reg  <= psum_next;
                        nasum_reg <= nasum_next;
                        nbsum_reg <= nbsum_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            s1_last_reg  <= s_tlast;
            s1_mode_reg  <= mode_reg;
            s1_pterm_reg <= pterm;
            s1_aa_reg    <= 32'($unsigned(32'(a_elem) * 32'(a_elem)));
            s1_bb_reg    <= 32'($unsigned(32'(b_elem) * 32'(b_elem)));
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pvd_queue.sv
// Two-entry job queue between the accumulator and the finishing engine.
// Uses pvd_pkg for the job record.
`default_nettype none
module pvd_queue
    import pvd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire pvd_job_t  push_data,
    output logic           push_ready,
    output logic           pop_valid,
    output pvd_job_t       pop_data,
    input  wire logic      pop
);
    pvd_job_t    mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end
endmodule
`default_nettype wire

FILE: rtl/pvd_back.sv
// Finishing engine: bit-pair square root, one multiply and a restoring
// divider turn a job into a distance. Uses pvd_pkg and the assertion macros.
`default_nettype none
`include "pairwise_vector_distance_macros.svh"
module pvd_back
    import pvd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          job_valid,
    input  wire pvd_job_t      job_data,
    output logic               job_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [DIST_W-1:0]  m_tdata
);
    localparam int DIFF_W = SUM_W + 1;
    localparam int DVD_W  = DIFF_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam int RCNT_W = $clog2(ROOT_W + 1);
    localparam int SQR_W  = ROOT_W + 3;

    typedef enum logic [2:0] {
        S_IDLE, S_ROOT_P, S_ROOT_A, S_ROOT_B, S_MUL, S_DIFF, S_DIV, S_OUT
    } state_t;

    state_t               state_reg;
    pvd_job_t             job_reg;
    logic [SUM_W-1:0]     x_reg;
    logic [SQR_W-1:0]     sq_rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [RCNT_W-1:0]    sq_cnt_reg;
    logic [ROOT_W-1:0]    na_reg;
    logic [ROOT_W-1:0]    nb_reg;
    logic [SUM_W-1:0]     den_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [SUM_W-1:0]     drem_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DCNT_W-1:0]    dcnt_reg;
    logic [DIST_W-1:0]    out_reg;

    logic [SQR_W-1:0]     sq_rem_sh;
    logic [SQR_W-1:0]     sq_trial;
    logic                 sq_ge;
    logic [ROOT_W-1:0]    root_next;
    logic                 sq_last;
    logic [SUM_W:0]       drem_sh;
    logic                 d_ge;
    logic [DVD_W-1:0]     quo_next;
    logic signed [DIFF_W:0] diff_s;

    // Square root: two radicand bits per step, one root bit out.
    assign sq_rem_sh = {sq_rem_reg[SQR_W-3:0], x_reg[SUM_W-1 -: 2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = sq_rem_sh >= sq_trial;
    assign root_next = {root_reg[ROOT_W-2:0], sq_ge};
    assign sq_last   = sq_cnt_reg == RCNT_W'(ROOT_W - 1);

    assign drem_sh  = {drem_reg, dvd_reg[DVD_W-1]};
    assign d_ge     = drem_sh >= {1'b0, den_reg};
    assign quo_next = {quo_reg[DVD_W-2:0], d_ge};

    assign diff_s = $signed({2'b00, den_reg})
                  - $signed({{2{job_reg.primary[SUM_W-1]}}, job_reg.primary});

    assign job_pop  = (state_reg == S_IDLE) && job_valid;
    assign m_tvalid = state_reg == S_OUT;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg    <= job_data;
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        sq_cnt_reg <= '0;
                        case (job_data.mode)
                            METRIC_CITYBLOCK: begin
                                out_reg   <= (|job_data.primary[SUM_W-1:DIST_W]) ? '1
                                             : job_data.primary[DIST_W-1:0];
                                state_reg <= S_OUT;
                            end
                            METRIC_EUCLID: begin
                                x_reg     <= job_data.primary;
                                state_reg <= S_ROOT_P;
                            end
                            METRIC_COSINE: begin
                                x_reg     <= job_data.norm_a;
                                state_reg <= S_ROOT_A;
                            end
                            default: begin
                                out_reg   <= '0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_ROOT_P, S_ROOT_A, S_ROOT_B: begin
                    sq_rem_reg <= sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
                    root_reg   <= root_next;
                    x_reg      <= {x_reg[SUM_W-3:0], 2'b00};
                    sq_cnt_reg <= sq_cnt_reg + RCNT_W'(1);
                    if (sq_last) begin
                        case (state_reg)
                            S_ROOT_P: begin
                                out_reg   <= DIST_W'(root_next);
                                state_reg <= S_OUT;
                            end
                            S_ROOT_A: begin
                                na_reg     <= root_next;
                                x_reg      <= job_reg.norm_b;
                                sq_rem_reg <= '0;
                                root_reg   <= '0;
                                sq_cnt_reg <= '0;
                                state_reg  <= S_ROOT_B;
                            end
                            default: begin
                                nb_reg <= root_next;
                                if (na_reg == '0 || root_next == '0) begin
                                    // zero norm reads as distance 1.0
                                    out_reg   <= DIST_W'(1) << FRAC_BITS;
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    den_reg   <= SUM_W'(na_reg * nb_reg);
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    if (diff_s[DIFF_W] || diff_s == '0) begin
                        out_reg   <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        dvd_reg   <= {diff_s[DIFF_W-1:0], {FRAC_BITS{1'b0}}};
                        drem_reg  <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    drem_reg <= d_ge ? SUM_W'(drem_sh - {1'b0, den_reg}) : SUM_W'(drem_sh);
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    quo_reg  <= quo_next;
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(DVD_W - 1)) begin
                        out_reg   <= (|quo_next[DVD_W-1:DIST_W]) ? '1
                                     : quo_next[DIST_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PVD_ASSERT_NEXT(a_pop_leaves_idle, job_pop, state_reg != S_IDLE)
    `PVD_ASSERT_SAME(a_div_rem_below_den, state_reg == S_DIV, drem_reg < den_reg)
    `PVD_ASSERT_SAME(a_mul_norms_nonzero, state_reg == S_MUL, na_reg != '0 && nb_reg != '0)
    `PVD_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
`default_nettype wire

FILE: rtl/pairwise_vector_distance.sv
// Pairwise vector distance: streams one element pair (a, b) per cycle, Q3.12, and on the
// pair with tlast returns one 32-bit unsigned Q.12 distance, saturated: cityblock, euclidean
// or cosine per metric_mode (0/1/2; 3 gives 0). Pairs are taken one per cycle while s_tready
// is high. Cityblock and unused metric 3 go straight to the output; euclidean adds a 24-step
// square root, cosine two 24-step square roots, a multiply, a difference and a bit-serial
// divide. A two-job queue lets the next vector accumulate while the previous result is
// finished; a closing pair stalls s_tready only while the queue is full. Write metric_mode
// only while no vector is in flight.
`default_nettype none
module pairwise_vector_distance
    import pvd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_wr_data,   // metric_mode
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,       // a_elem [15:0], b_elem [31:16]
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [DIST_W-1:0]       m_tdata        // distance [31:0]
);
    logic      push;
    logic      push_ready;
    logic      pop;
    logic      pop_valid;
    pvd_job_t  push_data;
    pvd_job_t  pop_data;

    pvd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .job_push    (push),
        .job_data    (push_data),
        .job_ready   (push_ready)
    );

    pvd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    pvd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_data  (pop_data),
        .job_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire
